// ===== hdl/smpg_pkg.sv =====
`default_nettype none
package smpg_pkg;

  localparam int POS_W = 12;
  localparam int SPD_W = 10;
  localparam int PER_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [PER_W-1:0] PER_MAX     = '1;
  localparam logic [PER_W-1:0] PER_RESET   = PER_W'(500);

  // tuser codes on the input channel
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic tick_acc;
    logic move_acc;
    logic div_step;
    logic per_load;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/smpg_ctrl.sv =====
`default_nettype none
module smpg_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire                    in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  input  smpg_pkg::dp_status_t   status,
  output smpg_pkg::ctrl_cmd_t    cmd
);
  import smpg_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        in_acc;

  assign slot_free = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == CMD_MOVE)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = slot_free;
        if (in_acc) begin
          if (in_tuser == CMD_MOVE) begin
            cmd.move_acc = 1'b1;
          end else begin
            cmd.tick_acc = 1'b1;
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.per_load = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/smpg_datapath.sv =====
`default_nettype none
module smpg_datapath #(
  parameter int STEPS_PER_MM     = 20,
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int TRAVEL_MM        = 150
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [smpg_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic [smpg_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire                                 cfg_data,
  input  smpg_pkg::ctrl_cmd_t                 cmd,
  output smpg_pkg::dp_status_t                status
);
  import smpg_pkg::*;

  localparam int FULL = TRAVEL_MM * STEPS_PER_MM;
  localparam int TW   = $clog2(FULL + 2 * STEPS_PER_MM + 4096) + 2;
  localparam int RW   = SPD_W + $clog2(STEPS_PER_MM + 1);
  localparam int DW   = $clog2(TICKS_PER_SECOND + 1);
  localparam int CW   = $clog2(DW);
  localparam int QW   = (DW > PER_W) ? DW : PER_W + 1;

  localparam logic signed [TW-1:0] FULL_S   = TW'(FULL);
  localparam logic signed [TW-1:0] OVER_HI  = TW'(FULL + 2 * STEPS_PER_MM);
  localparam logic signed [TW-1:0] OVER_LO  = -TW'(2 * STEPS_PER_MM);
  localparam logic signed [TW-1:0] CLAMP_LO = TW'(5 * STEPS_PER_MM);
  localparam logic signed [TW-1:0] CLAMP_HI = TW'((TRAVEL_MM - 5) * STEPS_PER_MM);
  localparam logic signed [TW-1:0] POS_MAX_S = TW'(POS_MAX);
  localparam logic [POS_W-1:0] LAST_RESET = (FULL > 4095) ? POS_MAX : POS_W'(FULL);
  localparam logic [DW-1:0]    DIVIDEND   = DW'(TICKS_PER_SECOND);
  localparam logic [RW-1:0]    STEPS_R    = RW'(STEPS_PER_MM);

  logic              end_mode_r;
  logic [POS_W-1:0]  last_r, pulse_cnt_r, pulse_tgt_r;
  logic [PER_W-1:0]  per_r, pc_r;
  logic              run_r, dir_r, fin_r;
  logic [RW-1:0]     rate_r, rem_r;
  logic [DW-1:0]     quo_r;
  logic [CW-1:0]     bit_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic [POS_W-1:0]  last_nxt, pulse_cnt_nxt, pulse_tgt_nxt;
  logic [PER_W-1:0]  per_nxt, pc_nxt;
  logic              run_nxt, dir_nxt, fin_nxt;

  // move geometry
  logic [POS_W-1:0]        tin;
  logic [SPD_W-1:0]        spd, spd_c;
  logic signed [TW-1:0]    tin_c, tgt, stored, travel, mag_w;
  logic [POS_W-1:0]        mag, stored_p;

  assign tin = in_tdata[POS_W-1:0];
  assign spd = in_tdata[POS_W +: SPD_W];
  assign spd_c = (spd == '0) ? SPD_W'(1) : spd;

  always_comb begin
    tin_c = TW'(tin);
    if (tin_c > FULL_S) tin_c = FULL_S;
    if (!end_mode_r) begin
      stored = tin_c;
      if (tin_c == FULL_S) tgt = OVER_HI;
      else if (tin_c == '0) tgt = OVER_LO;
      else tgt = tin_c;
    end else begin
      tgt = tin_c;
      if (tgt < CLAMP_LO) tgt = CLAMP_LO;
      else if (tgt > CLAMP_HI) tgt = CLAMP_HI;
      stored = tgt;
    end
    travel = tgt - TW'(last_r);
    mag_w  = travel[TW-1] ? -travel : travel;
    mag    = (mag_w > POS_MAX_S) ? POS_MAX : mag_w[POS_W-1:0];
    stored_p = (stored > POS_MAX_S) ? POS_MAX : stored[POS_W-1:0];
  end

  // one restoring division step per cycle
  logic [RW:0]   trial;
  logic          ge;
  logic [RW-1:0] rem_step;
  logic [QW-1:0] q_ext;
  logic [PER_W-1:0] q_sat;

  assign trial    = {rem_r, DIVIDEND[bit_r]};
  assign ge       = trial >= {1'b0, rate_r};
  assign rem_step = ge ? RW'(trial - {1'b0, rate_r}) : trial[RW-1:0];
  assign status.div_last = (bit_r == '0);

  always_comb begin
    q_ext = QW'(quo_r);
    if (q_ext == '0) q_sat = PER_W'(1);
    else if (q_ext > QW'(PER_MAX)) q_sat = PER_MAX;
    else q_sat = q_ext[PER_W-1:0];
  end

  // state update
  logic [PER_W:0] pc_inc;
  logic [POS_W-1:0] cnt_inc;

  assign pc_inc  = {1'b0, pc_r} + 1'b1;
  assign cnt_inc = pulse_cnt_r + 1'b1;

  always_comb begin
    last_nxt      = last_r;
    pulse_cnt_nxt = pulse_cnt_r;
    pulse_tgt_nxt = pulse_tgt_r;
    per_nxt       = per_r;
    pc_nxt        = pc_r;
    run_nxt       = run_r;
    dir_nxt       = dir_r;
    fin_nxt       = fin_r;
    priority if (cmd.move_acc) begin
      last_nxt      = stored_p;
      pulse_tgt_nxt = mag;
      dir_nxt       = !travel[TW-1] && (travel != '0);
      pulse_cnt_nxt = '0;
      pc_nxt        = '0;
      fin_nxt       = (mag == '0);
      run_nxt       = (mag != '0);
    end else if (cmd.tick_acc) begin
      if (run_r) begin
        if (pc_inc >= {1'b0, per_r}) begin
          pc_nxt = '0;
          if (cnt_inc >= pulse_tgt_r) begin
            fin_nxt       = 1'b1;
            run_nxt       = 1'b0;
            pulse_cnt_nxt = '0;
          end else begin
            pulse_cnt_nxt = cnt_inc;
          end
        end else begin
          pc_nxt = pc_inc[PER_W-1:0];
        end
      end
    end else if (cmd.per_load) begin
      per_nxt = q_sat;
    end
  end

  logic [PER_W:0] half;
  logic           step_nxt;

  assign half     = ({1'b0, per_nxt} + 1'b1) >> 1;
  assign step_nxt = run_nxt && ({1'b0, pc_nxt} < half);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_mode_r  <= 1'b0;
      last_r      <= LAST_RESET;
      pulse_cnt_r <= '0;
      pulse_tgt_r <= '0;
      per_r       <= PER_RESET;
      pc_r        <= '0;
      run_r       <= 1'b0;
      dir_r       <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) end_mode_r <= cfg_data;
      last_r      <= last_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      pulse_tgt_r <= pulse_tgt_nxt;
      per_r       <= per_nxt;
      pc_r        <= pc_nxt;
      run_r       <= run_nxt;
      dir_r       <= dir_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move_acc) begin
      rate_r <= RW'(spd_c * STEPS_R);
      rem_r  <= '0;
      quo_r  <= '0;
      bit_r  <= CW'(DW - 1);
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      quo_r <= {quo_r[DW-2:0], ge};
      if (bit_r != '0) bit_r <= bit_r - 1'b1;
    end
    if (cmd.load_out) begin
      out_r <= {4'b0, fin_nxt, run_nxt, dir_nxt, step_nxt};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

// ===== hdl/stepper_move_pulse_generator_unit.sv =====
`default_nettype none
// Channel | Direction | Beat contents
// in_     | slave     | tuser: command (0 tick, 1 move);
//         |           | tdata: target_position[11:0], speed[21:12]
// out_    | master    | tdata: step_out, direction, busy_res, done_res
// cfg_    | slave     | data: end_mode
//
// Ticks may arrive back to back while the out_ side takes each result.
// A move beat runs the bit-serial period divider, one quotient bit a cycle,
// and no new beat is taken until its result is loaded into the output register.
// Reset is synchronous; no clearing pass is needed.
// The result sits in an output register; a stalled out_ side holds in_tready low
// only once the register is full and not being taken.
module stepper_move_pulse_generator_unit #(
  parameter int STEPS_PER_MM     = 20,
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int TRAVEL_MM        = 150
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // target_position[11:0], speed[21:12], zero pad
  input  wire         in_tuser,   // command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // step_out, direction, busy_res, done_res, zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data    // end_mode
);
  import smpg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  smpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  smpg_datapath #(
    .STEPS_PER_MM     (STEPS_PER_MM),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .TRAVEL_MM        (TRAVEL_MM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== tb/stepper_move_pulse_generator_unit_test.sv =====
`timescale 1ns / 1ps

module stepper_move_pulse_generator_unit_test;
  import smpg_pkg::*;

  localparam int STEPS_PER_MM     = 20;
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int TRAVEL_MM        = 150;
  localparam int FULL_STEPS       = TRAVEL_MM * STEPS_PER_MM;
  localparam int NEAR_END         = 5 * STEPS_PER_MM;
  localparam int FAR_END          = (TRAVEL_MM - 5) * STEPS_PER_MM;
  localparam int N_PLAN           = 24;

  // lowest bit first: step_out, direction, busy_res, done_res
  typedef struct packed {
    logic done;
    logic busy;
    logic dir;
    logic step;
  } axis_out_t;

  typedef struct packed {
    logic             clamp;
    logic             cmd;
    logic [POS_W-1:0] tgt;
    logic [SPD_W-1:0] spd;
    logic             typed;
    axis_out_t        want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  // predictor state
  logic [POS_W-1:0] axis_pos;
  logic [POS_W-1:0] pulse_cnt;
  logic [POS_W-1:0] pulse_goal;
  logic [PER_W-1:0] period_len;
  logic [PER_W-1:0] tick_cnt;
  logic             moving;
  logic             axis_dir;
  logic             finished;
  logic             clamp_ends;

  axis_out_t axis_state_q[$];
  stim_row_t plan [N_PLAN];

  int send_idle;
  int recv_idle;
  int recv_hold;
  bit hold_pending;
  int beats_sent;
  int tick_beats;
  int move_beats;
  int results_seen;
  int moves_done;
  int steps_seen;
  int mismatches;
  axis_out_t got_beat;
  axis_out_t want_beat;
  axis_out_t prev_beat;

  stepper_move_pulse_generator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] %s", $realtime, msg);
  endtask

  function automatic axis_out_t advance_axis(logic cmd, logic [POS_W-1:0] tgt_in,
                                             logic [SPD_W-1:0] spd_in);
    int tgt;
    int stored;
    int travel;
    int mag;
    int q;
    axis_out_t res;
    if (cmd == CMD_MOVE) begin
      tgt = (int'(tgt_in) > FULL_STEPS) ? FULL_STEPS : int'(tgt_in);
      if (clamp_ends == 1'b0) begin
        stored = tgt;
        // ends are overdriven by 2 mm so the carriage seats on the stop
        if (tgt == FULL_STEPS) tgt = FULL_STEPS + 2 * STEPS_PER_MM;
        else if (tgt == 0) tgt = -2 * STEPS_PER_MM;
      end else begin
        if (tgt < NEAR_END) tgt = NEAR_END;
        else if (tgt > FAR_END) tgt = FAR_END;
        stored = tgt;
      end
      travel = tgt - int'(axis_pos);
      axis_dir = (travel > 0);
      mag = (travel < 0) ? -travel : travel;
      pulse_goal = (mag > 4095) ? POS_MAX : POS_W'(mag);
      q = TICKS_PER_SECOND / (((spd_in == '0) ? 1 : int'(spd_in)) * STEPS_PER_MM);
      period_len = (q < 1) ? PER_W'(1) : ((q > 65535) ? PER_MAX : PER_W'(q));
      axis_pos = POS_W'(stored);
      pulse_cnt = '0;
      tick_cnt = '0;
      moving = (mag != 0);
      finished = (mag == 0);
    end else if (moving) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= period_len) begin
        tick_cnt = '0;
        pulse_cnt = pulse_cnt + 1'b1;
        if (pulse_cnt >= pulse_goal) begin
          finished = 1'b1;
          moving = 1'b0;
          pulse_cnt = '0;
        end
      end
    end
    res.step = moving && (int'(tick_cnt) < (int'(period_len) + 1) / 2);
    res.dir  = axis_dir;
    res.busy = moving;
    res.done = finished;
    return res;
  endfunction

  // called and returns at a falling edge; valid stays up for a following beat
  task automatic push_beat(logic cmd, logic [POS_W-1:0] tgt, logic [SPD_W-1:0] spd,
                           logic typed, axis_out_t want);
    axis_out_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, spd, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = advance_axis(cmd, tgt, spd);
    axis_state_q.push_back(typed ? want : pred);
    if (cmd == CMD_MOVE) move_beats++;
    else tick_beats++;
    beats_sent++;
    if (hold_pending) begin
      recv_hold = 250;
      hold_pending = 0;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (axis_state_q.size() != 0);
  endtask

  task automatic write_end_mode(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    clamp_ends = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_run(int n);
    for (int k = 0; k < n; k++)
      push_beat(CMD_TICK, POS_W'($urandom), SPD_W'($urandom), 1'b0, '0);
  endtask

  task automatic run_phase(int n_items, int s_idle, int r_idle, logic mode, bit with_hold);
    int start;
    int delta;
    int ticks;
    int pick;
    logic [POS_W-1:0] tgt;
    drain_results();
    write_end_mode(mode);
    send_idle = s_idle;
    recv_idle = r_idle;
    hold_pending = with_hold;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // short fast move near the current position, mostly run to done
        delta = $urandom_range(0, 3);
        if ($urandom_range(1) != 0) tgt = POS_W'(int'(axis_pos) + delta);
        else tgt = (int'(axis_pos) >= delta) ? POS_W'(int'(axis_pos) - delta) : '0;
        push_beat(CMD_MOVE, tgt, SPD_W'($urandom_range(900, 1023)), 1'b0, '0);
        if ($urandom_range(3) != 0)
          ticks = int'(period_len) * int'(pulse_goal) + $urandom_range(0, 6);
        else
          ticks = $urandom_range(0, 2 * int'(period_len));
        if (ticks > 400) ticks = $urandom_range(0, 400);
        if (ticks > n_items - (beats_sent - start)) ticks = n_items - (beats_sent - start);
        tick_run(ticks);
      end else if (pick < 85) begin
        push_beat(CMD_MOVE, POS_W'($urandom_range(0, 4095)), SPD_W'($urandom_range(0, 1023)),
                  1'b0, '0);
        tick_run($urandom_range(0, 20));
      end else begin
        tick_run($urandom_range(1, 40));
      end
    end
  endtask

  // receiver side: random back-pressure, or a counted hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        out_tready <= 1'b0;
        recv_hold--;
      end else begin
        out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = axis_out_t'(out_tdata[3:0]);
      if (axis_state_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want_beat = axis_state_q.pop_front();
        if (got_beat.step !== want_beat.step)
          report_mismatch($sformatf("beat %0d step_out exp %0b got %0b", results_seen,
                                    want_beat.step, got_beat.step));
        if (got_beat.dir !== want_beat.dir)
          report_mismatch($sformatf("beat %0d direction exp %0b got %0b", results_seen,
                                    want_beat.dir, got_beat.dir));
        if (got_beat.busy !== want_beat.busy)
          report_mismatch($sformatf("beat %0d busy_res exp %0b got %0b", results_seen,
                                    want_beat.busy, got_beat.busy));
        if (got_beat.done !== want_beat.done)
          report_mismatch($sformatf("beat %0d done_res exp %0b got %0b", results_seen,
                                    want_beat.done, got_beat.done));
      end
      if (got_beat.done === 1'b1 && prev_beat.done !== 1'b1) moves_done++;
      if (got_beat.step === 1'b1 && prev_beat.step !== 1'b1) steps_seen++;
      prev_beat = got_beat;
      results_seen++;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    recv_hold  = 0;
    hold_pending = 0;
    prev_beat  = '0;
    axis_pos   = POS_W'(FULL_STEPS);
    pulse_cnt  = '0;
    pulse_goal = '0;
    period_len = PER_RESET;
    tick_cnt   = '0;
    moving     = 1'b0;
    axis_dir   = 1'b0;
    finished   = 1'b0;
    clamp_ends = 1'b0;
    send_idle  = 11;
    recv_idle  = 84;

    plan = '{
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b1, 4'b0000}, // idle after reset
      '{1'b0, CMD_MOVE, 12'd3000, 10'd0,    1'b1, 4'b0111}, // top end, speed zero
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000},
      '{1'b0, CMD_MOVE, 12'd4095, 10'd1023, 1'b0, 4'b0000}, // target past travel
      '{1'b0, CMD_TICK, 12'd4095, 10'd1023, 1'b0, 4'b0000},
      '{1'b0, CMD_MOVE, 12'd0,    10'd1000, 1'b0, 4'b0000}, // full travel down
      '{1'b0, CMD_MOVE, 12'd0,    10'd1023, 1'b0, 4'b0000}, // overdrive at bottom
      '{1'b0, CMD_MOVE, 12'd1,    10'd5,    1'b0, 4'b0000},
      '{1'b0, CMD_MOVE, 12'd1,    10'd5,    1'b1, 4'b1000}, // zero-length move
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b1, 4'b1000}, // idle tick keeps done
      '{1'b0, CMD_MOVE, 12'd3,    10'd1023, 1'b0, 4'b0000},
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000},
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000},
      '{1'b0, CMD_MOVE, 12'd6,    10'd512,  1'b0, 4'b0000}, // move while running
      '{1'b0, CMD_MOVE, 12'd2999, 10'd341,  1'b0, 4'b0000},
      '{1'b1, CMD_MOVE, 12'd0,    10'd1023, 1'b0, 4'b0000}, // clamped up to 5 mm
      '{1'b1, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000},
      '{1'b1, CMD_MOVE, 12'd4095, 10'd682,  1'b0, 4'b0000}, // clamped to 145 mm
      '{1'b1, CMD_MOVE, 12'd2900, 10'd1,    1'b1, 4'b1000},
      '{1'b1, CMD_MOVE, 12'd100,  10'd1023, 1'b0, 4'b0000},
      '{1'b1, CMD_MOVE, 12'd99,   10'd1023, 1'b1, 4'b1000}, // clamp makes it zero-length
      '{1'b1, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000},
      '{1'b0, CMD_MOVE, 12'd3000, 10'd1023, 1'b0, 4'b0000},
      '{1'b0, CMD_TICK, 12'd0,    10'd0,    1'b0, 4'b0000}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_end_mode(1'b0);

    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].clamp != clamp_ends) begin
        drain_results();
        write_end_mode(plan[i].clamp);
      end
      push_beat(plan[i].cmd, plan[i].tgt, plan[i].spd, plan[i].typed, plan[i].want);
    end

    run_phase(420, 11, 84, 1'b1, 0);
    run_phase(420, 84, 11, 1'b0, 0);
    run_phase(420, 0, 0, 1'b1, 1);

    drain_results();
    repeat (40) @(negedge clk);

    $display("Covered %0d tick beats and %0d move beats across both end modes,",
             tick_beats, move_beats);
    $display("seeing %0d finished moves and %0d step pulses in %0d result beats.",
             moves_done, steps_seen, results_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== stepper_move_pulse_generator_unit.f =====
hdl/smpg_pkg.sv
hdl/smpg_ctrl.sv
hdl/smpg_datapath.sv
hdl/stepper_move_pulse_generator_unit.sv
tb/stepper_move_pulse_generator_unit_test.sv
